/* hdl/inna_pkg.sv */
// shared types and constants for the impulse noise neighbor average block
package inna_pkg;

  // position class of one pixel, decided when it is accepted
  typedef struct packed {
    logic up;         // a row above exists, so the pixel above gets emitted
    logic last_row;   // pixel sits on the bottom row of the frame
    logic has_left;   // column >= 1
    logic has_left2;  // column >= 2
    logic has_right;  // column + 1 < frame width
    logic above2;     // row >= 2, pixel above has its own upper neighbor
    logic br;         // bottom-right pixel of the frame
  } item_flags_t;

  // which result of a pixel is being produced
  typedef enum logic [1:0] {
    PhUp,
    PhLeft,
    PhBr
  } phase_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegFrameRows = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameCols = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNoiseThr  = 2'd2;

  localparam int unsigned QueueDepth = 2;

endpackage

/* hdl/inna_front.sv */
// front end: takes pixels, tracks raster position, reads the raw line store
module inna_front #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 4096,
  parameter int unsigned PIXEL_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [$clog2(MAX_ROWS):0]     rows_i,
  input  logic [$clog2(MAX_COLS):0]     cols_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [PIXEL_BITS-1:0]         pixel_in_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output logic [PIXEL_BITS-1:0]         push_p_o,
  output logic [PIXEL_BITS-1:0]         push_t_o,
  output logic [PIXEL_BITS-1:0]         push_right_o,
  output logic [PIXEL_BITS-1:0]         push_left_o,
  output logic [$clog2(MAX_ROWS)-1:0]   push_row_o,
  output logic [$clog2(MAX_COLS)-1:0]   push_col_o,
  output inna_pkg::item_flags_t         push_flags_o
);

  localparam int unsigned RowW = $clog2(MAX_ROWS);
  localparam int unsigned ColW = $clog2(MAX_COLS);

  logic [PIXEL_BITS-1:0] raw_mem [MAX_COLS];

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW:0]   row_x;
  logic [ColW:0]   col_x, col_nx;
  logic [ColW-1:0] rd_addr;
  logic            accept;

  inna_pkg::item_flags_t flags_d;

  logic                  f_valid_q;
  logic [PIXEL_BITS-1:0] f_p_q;
  logic [PIXEL_BITS-1:0] f_right_q;
  logic [RowW-1:0]       f_row_q;
  logic [ColW-1:0]       f_col_q;
  inna_pkg::item_flags_t f_flags_q;

  logic [PIXEL_BITS-1:0] prev_right_q;
  logic [PIXEL_BITS-1:0] prev_p_q;
  logic [PIXEL_BITS-1:0] raw0_q;

  assign in_stall_o = f_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_valid_q && !q_full_i;

  assign row_x  = {1'b0, row_q};
  assign col_x  = {1'b0, col_q};
  assign col_nx = col_x + (ColW+1)'(1);

  always_comb begin
    flags_d.up        = (row_q != '0);
    flags_d.last_row  = (row_x == rows_i - (RowW+1)'(1));
    flags_d.has_left  = (col_q != '0);
    flags_d.has_left2 = (col_x >= (ColW+1)'(2));
    flags_d.has_right = (col_nx < cols_i);
    flags_d.above2    = (row_x >= (RowW+1)'(2));
    flags_d.br        = flags_d.last_row && (col_nx == cols_i);
  end

  // pixel right of this one, one row up
  assign rd_addr = flags_d.has_right ? col_nx[ColW-1:0] : '0;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_nx >= cols_i) begin
      col_d = '0;
      if (row_x + (RowW+1)'(1) >= rows_i) begin
        row_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = col_nx[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      f_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      f_valid_q <= accept || (f_valid_q && !push_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_mem[col_q] <= pixel_in_i;
      f_right_q      <= raw_mem[rd_addr];
      f_p_q          <= pixel_in_i;
      f_row_q        <= row_q;
      f_col_q        <= col_q;
      f_flags_q      <= flags_d;
    end
  end

  // raw pixel above: previous transaction's right read, or raw0_q at column 0
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      prev_right_q <= f_right_q;
      prev_p_q     <= f_p_q;
      if (f_col_q == '0) begin
        raw0_q <= f_p_q;
      end
    end
  end

  assign push_p_o     = f_p_q;
  assign push_t_o     = (f_col_q == '0) ? raw0_q : prev_right_q;
  assign push_right_o = f_right_q;
  assign push_left_o  = prev_p_q;
  assign push_row_o   = f_row_q;
  assign push_col_o   = f_col_q;
  assign push_flags_o = f_flags_q;

endmodule

/* hdl/inna_fifo.sv */
// small queue between the front end and the back end
module inna_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/inna_back.sv */
// back end: corrects pixels against their neighbors, holds the corrected line store
module inna_back #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 4096,
  parameter int unsigned PIXEL_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [PIXEL_BITS-1:0]         thr_i,
  input  logic                          q_valid_i,
  output logic                          pop_o,
  input  logic [PIXEL_BITS-1:0]         q_p_i,
  input  logic [PIXEL_BITS-1:0]         q_t_i,
  input  logic [PIXEL_BITS-1:0]         q_right_i,
  input  logic [PIXEL_BITS-1:0]         q_left_i,
  input  logic [$clog2(MAX_ROWS)-1:0]   q_row_i,
  input  logic [$clog2(MAX_COLS)-1:0]   q_col_i,
  input  inna_pkg::item_flags_t         q_flags_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PIXEL_BITS-1:0]         pixel_out_o,
  output logic [$clog2(MAX_ROWS)-1:0]   out_row_o,
  output logic [$clog2(MAX_COLS)-1:0]   out_col_o,
  output logic                          was_replaced_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o
);

  localparam int unsigned RowW = $clog2(MAX_ROWS);
  localparam int unsigned ColW = $clog2(MAX_COLS);
  localparam int unsigned SumW = PIXEL_BITS + 2;
  // rounding divide by three through a reciprocal multiply
  localparam int unsigned DivK = PIXEL_BITS + 4;
  localparam int unsigned ProdW = SumW + DivK;
  localparam logic [DivK-1:0] DivM = DivK'((2 ** DivK + 2) / 3);

  logic [PIXEL_BITS-1:0] fixed_mem [MAX_COLS];

  // working stage
  logic                  a_valid_q;
  logic [PIXEL_BITS-1:0] a_p_q, a_t_q, a_right_q, a_left_q, a_fabove_q;
  logic [RowW-1:0]       a_row_q;
  logic [ColW-1:0]       a_col_q;
  inna_pkg::item_flags_t a_flags_q;
  inna_pkg::phase_e      ph_q, ph_d;

  // corrected neighbors carried along the stream
  logic [PIXEL_BITS-1:0] left_fixed_q;
  logic [PIXEL_BITS-1:0] left2_q;
  logic [PIXEL_BITS-1:0] last_row_left_q;

  // output register
  logic                  o_valid_q;
  logic [PIXEL_BITS-1:0] o_pix_q;
  logic [RowW-1:0]       o_row_q;
  logic [ColW-1:0]       o_col_q;
  logic                  o_rep_q, o_last_q, o_done_q;

  logic o_free, fire, a_done, ph_final;

  logic [PIXEL_BITS-1:0] tgt;
  logic [PIXEL_BITS-1:0] nb [4];
  logic [3:0]            nb_en;
  logic [RowW-1:0]       res_row;
  logic [ColW-1:0]       res_col;

  logic [PIXEL_BITS-1:0] diff [4];
  logic [3:0]            near;
  logic [SumW-1:0]       sum;
  logic [2:0]            cnt;
  logic [SumW-1:0]       sum_r;
  logic [ProdW-1:0]      prod;
  logic [PIXEL_BITS-1:0] avg;
  logic                  noise;
  logic [PIXEL_BITS-1:0] res_pix;

  assign o_free = !o_valid_q || !out_stall_i;
  assign fire   = a_valid_q && a_flags_q.up && o_free;
  assign a_done = a_valid_q && (!a_flags_q.up || (fire && ph_final));
  assign pop_o  = q_valid_i && (!a_valid_q || a_done);

  // operands for the current phase
  always_comb begin
    tgt      = a_t_q;
    nb[0]    = a_p_q;
    nb[1]    = left_fixed_q;
    nb[2]    = a_right_q;
    nb[3]    = a_fabove_q;
    nb_en    = {a_flags_q.above2, a_flags_q.has_right, a_flags_q.has_left, 1'b1};
    res_row  = a_row_q - RowW'(1);
    res_col  = a_col_q;
    ph_final = !(a_flags_q.last_row && a_flags_q.has_left);
    case (ph_q)
      inna_pkg::PhUp: begin
        tgt      = a_t_q;
        nb[0]    = a_p_q;
        nb[1]    = left_fixed_q;
        nb[2]    = a_right_q;
        nb[3]    = a_fabove_q;
        nb_en    = {a_flags_q.above2, a_flags_q.has_right, a_flags_q.has_left, 1'b1};
        res_row  = a_row_q - RowW'(1);
        res_col  = a_col_q;
        // column 0 of the bottom row has no pixel to its left to emit
        ph_final = !(a_flags_q.last_row && a_flags_q.has_left);
      end
      inna_pkg::PhLeft: begin
        // pixel left on the bottom row: right is the new pixel, above is left2
        tgt      = a_left_q;
        nb[0]    = a_p_q;
        nb[1]    = left2_q;
        nb[2]    = last_row_left_q;
        nb[3]    = '0;
        nb_en    = {1'b0, a_flags_q.has_left2, 1'b1, 1'b1};
        res_row  = a_row_q;
        res_col  = a_col_q - ColW'(1);
        ph_final = !a_flags_q.br;
      end
      inna_pkg::PhBr: begin
        tgt      = a_p_q;
        nb[0]    = last_row_left_q;
        nb[1]    = left_fixed_q;
        nb[2]    = '0;
        nb[3]    = '0;
        nb_en    = 4'b0011;
        res_row  = a_row_q;
        res_col  = a_col_q;
        ph_final = 1'b1;
      end
      default: begin
        tgt      = a_t_q;
        ph_final = 1'b1;
      end
    endcase
  end

  // noise test and rounded neighbor average
  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      diff[i] = (tgt > nb[i]) ? tgt - nb[i] : nb[i] - tgt;
      near[i] = nb_en[i] && (diff[i] <= thr_i);
      if (nb_en[i]) begin
        sum = sum + SumW'(nb[i]);
        cnt = cnt + 3'd1;
      end
    end
    noise = (near == 4'b0000);
    sum_r = sum + SumW'(1);
    prod  = ProdW'(sum_r) * ProdW'(DivM);
    case (cnt)
      3'd2:    avg = PIXEL_BITS'((sum + SumW'(1)) >> 1);
      3'd3:    avg = PIXEL_BITS'(prod >> DivK);
      3'd4:    avg = PIXEL_BITS'((sum + SumW'(2)) >> 2);
      default: avg = PIXEL_BITS'(sum);
    endcase
    res_pix = noise ? avg : tgt;
  end

  always_comb begin
    ph_d = ph_q;
    if (fire) begin
      if (ph_final) begin
        ph_d = inna_pkg::PhUp;
      end else begin
        case (ph_q)
          inna_pkg::PhUp:   ph_d = inna_pkg::PhLeft;
          inna_pkg::PhLeft: ph_d = inna_pkg::PhBr;
          default:          ph_d = inna_pkg::PhUp;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      ph_q      <= inna_pkg::PhUp;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= pop_o || (a_valid_q && !a_done);
      ph_q      <= ph_d;
      o_valid_q <= fire || (o_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_p_q      <= q_p_i;
      a_t_q      <= q_t_i;
      a_right_q  <= q_right_i;
      a_left_q   <= q_left_i;
      a_row_q    <= q_row_i;
      a_col_q    <= q_col_i;
      a_flags_q  <= q_flags_i;
      a_fabove_q <= fixed_mem[q_col_i];
    end
    if (fire && (ph_q == inna_pkg::PhUp)) begin
      fixed_mem[a_col_q] <= res_pix;
      left_fixed_q       <= res_pix;
      left2_q            <= left_fixed_q;
    end
    if (fire && (ph_q == inna_pkg::PhLeft)) begin
      last_row_left_q <= res_pix;
    end
    if (fire) begin
      o_pix_q  <= res_pix;
      o_row_q  <= res_row;
      o_col_q  <= res_col;
      o_rep_q  <= noise;
      o_last_q <= ph_final;
      o_done_q <= (ph_q == inna_pkg::PhBr);
    end
  end

  assign out_valid_o    = o_valid_q;
  assign pixel_out_o    = o_pix_q;
  assign out_row_o      = o_row_q;
  assign out_col_o      = o_col_q;
  assign was_replaced_o = o_rep_q;
  assign last_of_run_o  = o_last_q;
  assign frame_done_o   = o_done_q;

endmodule

/* hdl/impulse_noise_neighbor_average.sv */
// top level of the four-neighbor impulse noise filter
//
// Pixels enter in raster order on in_valid_i / in_stall_o, one per transaction.
// A pixel is replaced by the rounded average of its existing 4-neighbors when it
// differs by more than the threshold from all of them; left and upper neighbors
// are already corrected. Results leave on out_valid_o / out_stall_i with their
// row and column. Registers (frame rows, frame columns, threshold) are written on
// the cfg channel; the user writes them only while idle, unchecked by the block;
// a size write restarts the frame. Output runs one row behind the input: the
// pixel above passes the front, queue, working and output registers after the
// pixel below is accepted; row 0 pixels alone give nothing. Steady rate is one
// pixel per cycle unless the output stalls; on the bottom row each pixel past
// column 0 gives two results (three at the last column), so the output register,
// which takes one result a cycle, sets the rate there and the input stalls once
// the queue is full. A stalled output holds its result and backs up through the
// queue to the input. Reset clears the position counters and all pipeline valids;
// line stores need no clearing: each entry used was written in the same frame.
module impulse_noise_neighbor_average #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 4096,
  parameter int unsigned PIXEL_BITS = 4,
  localparam int unsigned RowW  = $clog2(MAX_ROWS),
  localparam int unsigned ColW  = $clog2(MAX_COLS),
  localparam int unsigned WideW = (RowW >= ColW) ? RowW + 1 : ColW + 1,
  localparam int unsigned CfgW  = (WideW >= PIXEL_BITS) ? WideW : PIXEL_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [PIXEL_BITS-1:0]         pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PIXEL_BITS-1:0]         pixel_out_o,
  output logic [RowW-1:0]               out_row_o,
  output logic [ColW-1:0]               out_col_o,
  output logic                          was_replaced_o,
  output logic                          last_of_run_o,
  output logic                          frame_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [inna_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]               cfg_wdata_i
);

  localparam logic [RowW:0] RowsRst = (MAX_ROWS < 20) ? (RowW+1)'(MAX_ROWS) : (RowW+1)'(20);
  localparam logic [ColW:0] ColsRst = (MAX_COLS < 30) ? (ColW+1)'(MAX_COLS) : (ColW+1)'(30);
  localparam int unsigned QW = 4 * PIXEL_BITS + RowW + ColW + $bits(inna_pkg::item_flags_t);

  logic [RowW:0]           rows_q, rows_w;
  logic [ColW:0]           cols_q, cols_w;
  logic [PIXEL_BITS-1:0]   thr_q;
  logic                    cfg_we, restart;

  logic                    push, q_full, q_valid, pop;
  logic [QW-1:0]           q_wdata, q_rdata;
  logic [PIXEL_BITS-1:0]   f_p, f_t, f_right, f_left;
  logic [RowW-1:0]         f_row;
  logic [ColW-1:0]         f_col;
  inna_pkg::item_flags_t   f_flags;
  logic [PIXEL_BITS-1:0]   b_p, b_t, b_right, b_left;
  logic [RowW-1:0]         b_row;
  logic [ColW-1:0]         b_col;
  inna_pkg::item_flags_t   b_flags;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_index_i == inna_pkg::RegFrameRows) ||
                                  (cfg_index_i == inna_pkg::RegFrameCols));

  // sizes are stored already clamped to the supported range
  always_comb begin
    rows_w = cfg_wdata_i[RowW:0];
    if (rows_w < (RowW+1)'(2)) begin
      rows_w = (RowW+1)'(2);
    end else if (rows_w > (RowW+1)'(MAX_ROWS)) begin
      rows_w = (RowW+1)'(MAX_ROWS);
    end
    cols_w = cfg_wdata_i[ColW:0];
    if (cols_w < (ColW+1)'(2)) begin
      cols_w = (ColW+1)'(2);
    end else if (cols_w > (ColW+1)'(MAX_COLS)) begin
      cols_w = (ColW+1)'(MAX_COLS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsRst;
      cols_q <= ColsRst;
      thr_q  <= PIXEL_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        inna_pkg::RegFrameRows: rows_q <= rows_w;
        inna_pkg::RegFrameCols: cols_q <= cols_w;
        inna_pkg::RegNoiseThr:  thr_q  <= cfg_wdata_i[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  inna_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .rows_i       (rows_q),
    .cols_i       (cols_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_p_o     (f_p),
    .push_t_o     (f_t),
    .push_right_o (f_right),
    .push_left_o  (f_left),
    .push_row_o   (f_row),
    .push_col_o   (f_col),
    .push_flags_o (f_flags)
  );

  assign q_wdata = {f_flags, f_row, f_col, f_p, f_t, f_right, f_left};
  assign {b_flags, b_row, b_col, b_p, b_t, b_right, b_left} = q_rdata;

  inna_fifo #(
    .WIDTH (QW),
    .DEPTH (inna_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  inna_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .thr_i          (thr_q),
    .q_valid_i      (q_valid),
    .pop_o          (pop),
    .q_p_i          (b_p),
    .q_t_i          (b_t),
    .q_right_i      (b_right),
    .q_left_i       (b_left),
    .q_row_i        (b_row),
    .q_col_i        (b_col),
    .q_flags_i      (b_flags),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .was_replaced_o (was_replaced_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

/* hdl/inna_checker.sv */
// port-level checks for the impulse noise filter, bound to the top level
module inna_checker #(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned MAX_ROWS   = 4096,
  parameter int unsigned PIXEL_BITS = 4
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [PIXEL_BITS-1:0]       pixel_out_o,
  input logic [$clog2(MAX_ROWS)-1:0] out_row_o,
  input logic [$clog2(MAX_COLS)-1:0] out_col_o,
  input logic                        was_replaced_o,
  input logic                        last_of_run_o,
  input logic                        frame_done_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({pixel_out_o, out_row_o, out_col_o, was_replaced_o, last_of_run_o, frame_done_o}))
    else $error("result changed while stalled");

  // input stall only comes up after a pixel was taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted pixel");

  // bottom-right result ends its run and is on neither row 0 nor column 0
  a_frame_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_of_run_o && (out_row_o != '0) && (out_col_o != '0))
    else $error("frame done on a bad result");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("block not idle after reset");

endmodule

bind impulse_noise_neighbor_average inna_checker #(
  .MAX_COLS   (MAX_COLS),
  .MAX_ROWS   (MAX_ROWS),
  .PIXEL_BITS (PIXEL_BITS)
) u_inna_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_out_o    (pixel_out_o),
  .out_row_o      (out_row_o),
  .out_col_o      (out_col_o),
  .was_replaced_o (was_replaced_o),
  .last_of_run_o  (last_of_run_o),
  .frame_done_o   (frame_done_o)
);
